@@ design/dhp_pkg.sv @@
// Shared types and constants for the drive distance / heading PID core.
// No dependencies; every other design file refers to this package by scoped names.
package dhp_pkg;

    // Operand width of one gain product (the error sums are the widest)
    localparam int TERM_W = 48;
    // Gain width (Q16.16)
    localparam int GAIN_W = 32;
    // Saturated gain product: +-2^61 needs 63 bits
    localparam int PROD_W = 63;
    localparam logic signed [PROD_W-1:0] PROD_MAX = 63'sh2000_0000_0000_0000;

    // Pipeline advance controls, driven by the top level
    typedef struct packed {
        logic load;     // input request accepted, stage 1 and state update
        logic adv2;     // partial product stage may take new data
        logic adv3;     // saturated product stage may take new data
        logic adv_out;  // result register may take new data
    } pipe_ctl_t;

endpackage

@@ design/drive_distance_heading_pid_core.sv @@
// Top level of the drive distance / heading PID core: configuration registers,
// stream handshake and pipeline control. Depends on dhp_pkg, dhp_err, dhp_term, dhp_mix.

// One request per clock is accepted while the result stream does not stall the
// pipeline. The request passes four register stages: error stage (loaded at
// acceptance), partial product stage, product saturation stage and output
// register, from which its pair of drive commands goes out on the result stream.
// Each 48x32 gain product is split into a 32x32 and a 17x32 multiply in the
// partial product stage and recombined in the next stage. Error
// sums, last errors and the heading setpoint update in the cycle a request is
// accepted, so consecutive requests see the state left by the previous one.
// Each stage moves on whenever the stage after it is empty or moving, so a
// stalled output holds only the stages behind it that are full.
// Gains are Q16.16; drive commands use 32768 as full forward. Write the
// configuration registers only while no request is in flight.
module drive_distance_heading_pid_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // target[23:0], measured_distance[47:24], gyro_yaw[63:48]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // left_drive[17:0], right_drive[35:18], zero fill
);

    typedef enum logic [2:0] {
        REG_KP_DIST  = 3'd0,
        REG_KI_DIST  = 3'd1,
        REG_KD_DIST  = 3'd2,
        REG_KP_HEAD  = 3'd3,
        REG_KI_HEAD  = 3'd4,
        REG_KD_HEAD  = 3'd5,
        REG_WIN_DIST = 3'd6,
        REG_WIN_HEAD = 3'd7
    } cfg_reg_t;

    logic signed [31:0] kp_dist_reg;
    logic signed [31:0] ki_dist_reg;
    logic signed [31:0] kd_dist_reg;
    logic signed [31:0] kp_head_reg;
    logic signed [31:0] ki_head_reg;
    logic signed [31:0] kd_head_reg;
    logic [22:0]        win_dist_reg;
    logic [14:0]        win_head_reg;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               out_valid_reg;
    logic               turn2_reg;
    logic               turn3_reg;

    logic               rdy_out;
    logic               rdy3;
    logic               rdy2;
    logic               rdy1;
    dhp_pkg::pipe_ctl_t ctl;

    logic signed [24:0] dist_err;
    logic signed [47:0] dist_sum;
    logic signed [31:0] dist_delta;
    logic signed [16:0] head_err;
    logic signed [47:0] head_sum;
    logic signed [17:0] head_delta;
    logic               turn1;

    logic signed [dhp_pkg::PROD_W-1:0] dist_p;
    logic signed [dhp_pkg::PROD_W-1:0] dist_i;
    logic signed [dhp_pkg::PROD_W-1:0] dist_d;
    logic signed [dhp_pkg::PROD_W-1:0] head_p;
    logic signed [dhp_pkg::PROD_W-1:0] head_i;
    logic signed [dhp_pkg::PROD_W-1:0] head_d;

    logic signed [17:0] left_drive;
    logic signed [17:0] right_drive;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_dist_reg  <= '0;
            ki_dist_reg  <= '0;
            kd_dist_reg  <= '0;
            kp_head_reg  <= '0;
            ki_head_reg  <= '0;
            kd_head_reg  <= '0;
            win_dist_reg <= 23'd6144;
            win_head_reg <= 15'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KP_DIST:  kp_dist_reg  <= cfg_data;
                REG_KI_DIST:  ki_dist_reg  <= cfg_data;
                REG_KD_DIST:  kd_dist_reg  <= cfg_data;
                REG_KP_HEAD:  kp_head_reg  <= cfg_data;
                REG_KI_HEAD:  ki_head_reg  <= cfg_data;
                REG_KD_HEAD:  kd_head_reg  <= cfg_data;
                REG_WIN_DIST: win_dist_reg <= cfg_data[22:0];
                REG_WIN_HEAD: win_head_reg <= cfg_data[14:0];
                default:      win_head_reg <= win_head_reg;
            endcase
        end
    end

    // A stage takes new data when it is empty or the stage after it is taking its data
    assign rdy_out     = !out_valid_reg || m_axis_tready;
    assign rdy3        = !v3_reg || rdy_out;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign ctl.load    = s_axis_tvalid && rdy1;
    assign ctl.adv2    = rdy2;
    assign ctl.adv3    = rdy3;
    assign ctl.adv_out = rdy_out;

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_axis_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_out)
                out_valid_reg <= v3_reg;
        end
    end

    // Carry the turn-mode clamp select alongside the products
    always_ff @(posedge clk)
    begin
        if (rdy2)
            turn2_reg <= turn1;
        if (rdy3)
            turn3_reg <= turn2_reg;
    end

    dhp_err u_err (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .ctl                      (ctl),
        .op                       (s_axis_tuser),
        .target                   (s_axis_tdata[23:0]),
        .measured_distance        (s_axis_tdata[47:24]),
        .gyro_yaw                 (s_axis_tdata[63:48]),
        .distance_integral_window (win_dist_reg),
        .heading_integral_window  (win_head_reg),
        .dist_err                 (dist_err),
        .dist_sum                 (dist_sum),
        .dist_delta               (dist_delta),
        .head_err                 (head_err),
        .head_sum                 (head_sum),
        .head_delta               (head_delta),
        .turn_only                (turn1)
    );

    dhp_term u_dist_p (
        .clk  (clk),
        .ctl  (ctl),
        .x    (dhp_pkg::TERM_W'(dist_err)),
        .gain (kp_dist_reg),
        .prod (dist_p)
    );

    dhp_term u_dist_i (
        .clk  (clk),
        .ctl  (ctl),
        .x    (dist_sum),
        .gain (ki_dist_reg),
        .prod (dist_i)
    );

    dhp_term u_dist_d (
        .clk  (clk),
        .ctl  (ctl),
        .x    (dhp_pkg::TERM_W'(dist_delta)),
        .gain (kd_dist_reg),
        .prod (dist_d)
    );

    dhp_term u_head_p (
        .clk  (clk),
        .ctl  (ctl),
        .x    (dhp_pkg::TERM_W'(head_err)),
        .gain (kp_head_reg),
        .prod (head_p)
    );

    dhp_term u_head_i (
        .clk  (clk),
        .ctl  (ctl),
        .x    (head_sum),
        .gain (ki_head_reg),
        .prod (head_i)
    );

    dhp_term u_head_d (
        .clk  (clk),
        .ctl  (ctl),
        .x    (dhp_pkg::TERM_W'(head_delta)),
        .gain (kd_head_reg),
        .prod (head_d)
    );

    dhp_mix u_mix (
        .clk         (clk),
        .ctl         (ctl),
        .turn_only   (turn3_reg),
        .dist_p      (dist_p),
        .dist_i      (dist_i),
        .dist_d      (dist_d),
        .head_p      (head_p),
        .head_i      (head_i),
        .head_d      (head_d),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, right_drive, left_drive};

endmodule

@@ design/dhp_err.sv @@
// Error stage: distance and heading errors, integral windows and sums, deltas,
// and the controller state. Depends on dhp_pkg.
module dhp_err (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dhp_pkg::pipe_ctl_t       ctl,
    input  logic [1:0]               op,
    input  logic signed [23:0]       target,
    input  logic signed [23:0]       measured_distance,
    input  logic signed [15:0]       gyro_yaw,
    input  logic [22:0]              distance_integral_window,
    input  logic [14:0]              heading_integral_window,
    output logic signed [24:0]       dist_err,
    output logic signed [47:0]       dist_sum,
    output logic signed [31:0]       dist_delta,
    output logic signed [16:0]       head_err,
    output logic signed [47:0]       head_sum,
    output logic signed [17:0]       head_delta,
    output logic                     turn_only
);

    typedef enum logic [1:0] {
        OP_DRIVE = 2'd0,
        OP_TURN  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    localparam logic signed [6:0]  TICK_SCALE = 7'sd50;
    localparam logic signed [16:0] HALF_TURN  = 17'sd18000;
    localparam logic signed [16:0] FULL_TURN  = 17'sd36000;
    localparam logic signed [47:0] SUM_MAX    = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SUM_MIN    = {1'b1, {47{1'b0}}};

    // Clamp a grown sum back to the 48-bit accumulator range
    function automatic logic signed [47:0] sat_sum(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > 49'(SUM_MAX))
            r = SUM_MAX;
        else if (v < 49'(SUM_MIN))
            r = SUM_MIN;
        else
            r = 48'(v);
        return r;
    endfunction

    op_t op_e;

    // Controller state
    logic signed [47:0] dsum_reg;
    logic signed [24:0] dlast_reg;
    logic signed [47:0] hsum_reg;
    logic signed [16:0] hlast_reg;
    logic signed [15:0] sp_reg;

    // Stage 1 payload
    logic signed [24:0] de_reg;
    logic signed [47:0] ds_reg;
    logic signed [31:0] dd_reg;
    logic signed [16:0] he_reg;
    logic signed [47:0] hs_reg;
    logic signed [17:0] hd_reg;
    logic               turn_reg;

    logic signed [24:0] ed;
    logic signed [30:0] ed_scaled;
    logic signed [48:0] dsum_wide;
    logic signed [47:0] dsum_next;
    logic signed [25:0] dd_diff;
    logic signed [31:0] dd;
    logic signed [15:0] sp_sat;
    logic signed [15:0] sp_use;
    logic signed [16:0] eh_raw;
    logic signed [16:0] eh;
    logic signed [22:0] eh_scaled;
    logic signed [48:0] hsum_wide;
    logic signed [47:0] hsum_next;
    logic signed [17:0] dh;

    logic signed [24:0] de_next;
    logic signed [47:0] ds_next;
    logic signed [31:0] dd_next;
    logic signed [16:0] he_next;
    logic signed [47:0] hs_next;
    logic signed [17:0] hd_next;
    logic               turn_next;

    assign op_e = op_t'(op);

    // Distance error, windowed integral and scaled derivative
    always_comb
    begin
        ed        = 25'(target) - 25'(measured_distance);
        ed_scaled = 31'(ed) * TICK_SCALE;
        dsum_wide = 49'(dsum_reg) + 49'(ed_scaled);
        if (ed < $signed({2'b00, distance_integral_window}))
            dsum_next = sat_sum(dsum_wide);
        else
            dsum_next = '0;
        dd_diff = 26'(ed) - 26'(dlast_reg);
        dd      = 32'(dd_diff) * TICK_SCALE;
    end

    // Heading error with one wrap, windowed integral and raw derivative
    always_comb
    begin
        if (target > 24'sd32767)
            sp_sat = 16'sh7FFF;
        else if (target < -24'sd32768)
            sp_sat = 16'sh8000;
        else
            sp_sat = 16'(target);
        sp_use = (op_e == OP_TURN) ? sp_sat : sp_reg;
        eh_raw = 17'(sp_use) + 17'(gyro_yaw);
        eh     = eh_raw;
        if (eh > HALF_TURN)
            eh = eh - FULL_TURN;
        if (eh < -HALF_TURN)
            eh = eh + FULL_TURN;
        eh_scaled = 23'(eh) * TICK_SCALE;
        hsum_wide = 49'(hsum_reg) + 49'(eh_scaled);
        if (eh < $signed({2'b00, heading_integral_window}))
            hsum_next = sat_sum(hsum_wide);
        else
            hsum_next = '0;
        dh = 18'(eh) - 18'(hlast_reg);
    end

    // Select the operands handed to the product stage; zero operands give a zero result
    always_comb
    begin
        de_next   = '0;
        ds_next   = '0;
        dd_next   = '0;
        he_next   = '0;
        hs_next   = '0;
        hd_next   = '0;
        turn_next = 1'b0;
        case (op_e)
            OP_DRIVE:
            begin
                de_next = ed;
                ds_next = dsum_next;
                dd_next = dd;
                he_next = eh;
                hs_next = hsum_next;
                hd_next = dh;
            end
            OP_TURN:
            begin
                he_next   = eh;
                hd_next   = dh;
                turn_next = 1'b1;
            end
            default:
            begin
                turn_next = 1'b0;
            end
        endcase
    end

    // Update controller state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsum_reg  <= '0;
            dlast_reg <= '0;
            hsum_reg  <= '0;
            hlast_reg <= '0;
            sp_reg    <= '0;
        end
        else if (ctl.load)
        begin
            case (op_e)
                OP_DRIVE:
                begin
                    dsum_reg  <= dsum_next;
                    dlast_reg <= ed;
                    hsum_reg  <= hsum_next;
                    hlast_reg <= eh;
                end
                OP_TURN:
                begin
                    sp_reg    <= sp_sat;
                    hlast_reg <= eh;
                end
                OP_CLEAR:
                begin
                    dsum_reg  <= '0;
                    dlast_reg <= '0;
                    hsum_reg  <= '0;
                    hlast_reg <= '0;
                end
                default:
                begin
                    sp_reg <= sp_reg;
                end
            endcase
        end
    end

    // Stage 1 payload register
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            de_reg   <= de_next;
            ds_reg   <= ds_next;
            dd_reg   <= dd_next;
            he_reg   <= he_next;
            hs_reg   <= hs_next;
            hd_reg   <= hd_next;
            turn_reg <= turn_next;
        end
    end

    assign dist_err   = de_reg;
    assign dist_sum   = ds_reg;
    assign dist_delta = dd_reg;
    assign head_err   = he_reg;
    assign head_sum   = hs_reg;
    assign head_delta = hd_reg;
    assign turn_only  = turn_reg;

endmodule

@@ design/dhp_term.sv @@
// One saturating gain product: 48-bit operand times 32-bit gain, split into two
// registered partial products, then combined and clamped to +-2^61. Depends on dhp_pkg.
module dhp_term (
    input  logic                                clk,
    input  dhp_pkg::pipe_ctl_t                  ctl,
    input  logic signed [dhp_pkg::TERM_W-1:0]   x,
    input  logic signed [dhp_pkg::GAIN_W-1:0]   gain,
    output logic signed [dhp_pkg::PROD_W-1:0]   prod
);

    logic signed [63:0]                  hi_reg;
    logic signed [48:0]                  lo_reg;
    logic signed [79:0]                  full;
    logic signed [dhp_pkg::PROD_W-1:0]   prod_next;
    logic signed [dhp_pkg::PROD_W-1:0]   prod_reg;

    // Partial products: upper 32 bits signed, lower 16 bits unsigned
    always_ff @(posedge clk)
    begin
        if (ctl.adv2)
        begin
            hi_reg <= $signed(x[47:16]) * gain;
            lo_reg <= $signed({1'b0, x[15:0]}) * gain;
        end
    end

    // Recombine and clamp
    always_comb
    begin
        full = (80'(hi_reg) <<< 16) + 80'(lo_reg);
        if (full > 80'(dhp_pkg::PROD_MAX))
            prod_next = dhp_pkg::PROD_MAX;
        else if (full < -(80'(dhp_pkg::PROD_MAX)))
            prod_next = -dhp_pkg::PROD_MAX;
        else
            prod_next = dhp_pkg::PROD_W'(full);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv3)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ design/dhp_mix.sv @@
// Output stage: sums the three terms of each controller, shifts out the Q16
// fraction, clamps, and mixes arcade style into the result register. Depends on dhp_pkg.
module dhp_mix (
    input  logic                                clk,
    input  dhp_pkg::pipe_ctl_t                  ctl,
    input  logic                                turn_only,
    input  logic signed [dhp_pkg::PROD_W-1:0]   dist_p,
    input  logic signed [dhp_pkg::PROD_W-1:0]   dist_i,
    input  logic signed [dhp_pkg::PROD_W-1:0]   dist_d,
    input  logic signed [dhp_pkg::PROD_W-1:0]   head_p,
    input  logic signed [dhp_pkg::PROD_W-1:0]   head_i,
    input  logic signed [dhp_pkg::PROD_W-1:0]   head_d,
    output logic signed [17:0]                  left_drive,
    output logic signed [17:0]                  right_drive
);

    localparam logic signed [16:0] CMD_ONE  = 17'sd32768;
    localparam logic signed [16:0] CMD_HALF = 17'sd16384;

    logic signed [64:0] dacc;
    logic signed [64:0] hacc;
    logic signed [48:0] dval;
    logic signed [48:0] hval;
    logic signed [16:0] hlim;
    logic signed [16:0] fwd;
    logic signed [16:0] turn;
    logic signed [17:0] left_reg;
    logic signed [17:0] right_reg;

    // Sum, floor shift and clamp both controllers
    always_comb
    begin
        dacc = 65'(dist_p) + 65'(dist_i) + 65'(dist_d);
        hacc = 65'(head_p) + 65'(head_i) + 65'(head_d);
        dval = 49'(dacc >>> 16);
        hval = 49'(hacc >>> 16);
        hlim = turn_only ? CMD_ONE : CMD_HALF;
        if (dval > 49'(CMD_ONE))
            fwd = CMD_ONE;
        else if (dval < -(49'(CMD_ONE)))
            fwd = -CMD_ONE;
        else
            fwd = 17'(dval);
        if (hval > 49'(hlim))
            turn = hlim;
        else if (hval < -(49'(hlim)))
            turn = -hlim;
        else
            turn = 17'(hval);
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.adv_out)
        begin
            left_reg  <= 18'(fwd) - 18'(turn);
            right_reg <= 18'(fwd) + 18'(turn);
        end
    end

    assign left_drive  = left_reg;
    assign right_drive = right_reg;

endmodule
